FILE: rtl/core/ssdf_pkg.sv
// ----------------------------------------------------------------------------
// ssdf_pkg
// Types and constants shared by the splat select/delete flag block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdf_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_CLEAR    = 3'd0,
        REQ_SEL_ALL  = 3'd1,
        REQ_SEL_NONE = 3'd2,
        REQ_BOX      = 3'd3,
        REQ_DELETE   = 3'd4,
        REQ_FILTER   = 3'd5,
        REQ_QUERY    = 3'd6
    } t_req;

    // box select modes
    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z = 3'd2;
    localparam logic [2:0] CFG_HALF_X   = 3'd3;
    localparam logic [2:0] CFG_HALF_Y   = 3'd4;
    localparam logic [2:0] CFG_HALF_Z   = 3'd5;
    localparam logic [2:0] CFG_MODE     = 3'd6;
    localparam logic [2:0] CFG_THRESH   = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 24;
    localparam int HALF_W     = 23;
    localparam int DIFF_W     = POS_W + 1;
    localparam int ROW_W      = 16;
    localparam int OPA_W      = 16;

    localparam logic [OPA_W-1:0] THRESH_RESET = 16'h8000;

    typedef struct packed {
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
        logic [HALF_W-1:0]       half_x;
        logic [HALF_W-1:0]       half_y;
        logic [HALF_W-1:0]       half_z;
        logic [1:0]              mode;
        logic signed [OPA_W-1:0] thresh;
    } t_cfg;

    // stored marks: bit 0 selected, bit 1 deleted
    typedef struct packed {
        logic del;
        logic sel;
    } t_flags;

    // item held between the accept register and the result register
    typedef struct packed {
        t_req                     req;
        logic [ROW_W-1:0]         row;
        logic                     in_range;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic                     opa_lt;
    } t_stage;

endpackage

`default_nettype wire

FILE: rtl/core/ssdf_in_if.sv
// ----------------------------------------------------------------------------
// ssdf_in_if
// Request channel: one edit for one splat row per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssdf_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [15:0]        row_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] opacity_logit;

    modport source (
        output valid, req_type, row_index, pos_x, pos_y, pos_z, opacity_logit,
        input  ready
    );
    modport sink (
        input  valid, req_type, row_index, pos_x, pos_y, pos_z, opacity_logit,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/ssdf_out_if.sv
// ----------------------------------------------------------------------------
// ssdf_out_if
// Result channel: the row's marks after the edit, one beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssdf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_row;
    logic        is_selected;
    logic        is_deleted;
    logic        take_transform;
    logic        keep_row;

    modport source (
        output valid, out_row, is_selected, is_deleted, take_transform, keep_row,
        input  ready
    );
    modport sink (
        input  valid, out_row, is_selected, is_deleted, take_transform, keep_row,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/splat_select_delete_flags.sv
// path: request beat -> accept register -> result register -> result beat
// throughput: one request per cycle unless stalled; the flag read-modify-write
//   forwards the last write so back-to-back edits of the same row stay exact
// reset: configuration returns to its reset values and the flag RAM is swept
//   to zero, one row per cycle, all ROW_COUNT rows (65536 by default), with
//   request ready held low; configuration writes are taken during the sweep
// ----------------------------------------------------------------------------
// splat_select_delete_flags
// Selected and deleted marks for every splat row, edited one row per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module splat_select_delete_flags #(
    parameter int ROW_COUNT = 65536
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ssdf_in_if.sink                             i_req,
    ssdf_out_if.source                          o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [ssdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssdf_pkg::*;

    localparam int ADDR_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam logic [24:0] ROW_LIMIT = 25'(ROW_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ROW_COUNT - 1);

    t_cfg cfg;

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_s1_valid;
    t_stage            r_s1;
    logic [ADDR_W-1:0] r_s1_addr;
    t_stage            n_s1;
    logic [ADDR_W-1:0] n_s1_addr;

    logic              r_last_valid;
    logic [ADDR_W-1:0] r_last_addr;
    t_flags            r_last_flags;

    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    t_flags            r_out_flags;
    logic              r_out_keep;

    logic              accept;
    logic              s1_go;
    logic              item_wr;
    logic [23:0]       row_wide;
    logic [1:0]        ram_rdata;
    t_flags            old_flags;
    t_flags            new_flags;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [1:0]        ram_wdata;

    ssdf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign s1_go        = !r_out_valid || o_res.ready;
    assign i_req.ready  = !r_clearing && (!r_s1_valid || s1_go);
    assign accept       = i_req.valid && i_req.ready;

    // front end: address, range check, box differences and opacity compare
    assign row_wide = {8'b0, i_req.row_index};

    always_comb begin
        n_s1_addr   = row_wide[ADDR_W-1:0];
        n_s1.req    = t_req'(i_req.req_type);
        n_s1.row    = i_req.row_index;
        n_s1.in_range = {9'b0, i_req.row_index} < ROW_LIMIT;
        n_s1.dx     = {i_req.pos_x[POS_W-1], i_req.pos_x}
                    - {cfg.center_x[POS_W-1], cfg.center_x};
        n_s1.dy     = {i_req.pos_y[POS_W-1], i_req.pos_y}
                    - {cfg.center_y[POS_W-1], cfg.center_y};
        n_s1.dz     = {i_req.pos_z[POS_W-1], i_req.pos_z}
                    - {cfg.center_z[POS_W-1], cfg.center_z};
        n_s1.opa_lt = i_req.opacity_logit < cfg.thresh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= n_s1;
            r_s1_addr <= n_s1_addr;
        end
    end

    // flag store: the sweep owns the write port until it finishes
    assign item_wr   = r_s1_valid && s1_go && r_s1.in_range;
    assign ram_we    = r_clearing || item_wr;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clearing ? 2'b00 : new_flags;

    ssdf_ram #(
        .WIDTH  (2),
        .DEPTH  (ROW_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (n_s1_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) r_clearing <= 1'b0;
        end
    end

    // the write made as this item was read is not yet in the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
        end else if (r_clearing) begin
            r_last_valid <= 1'b0;
        end else if (item_wr) begin
            r_last_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_wr) begin
            r_last_addr  <= r_s1_addr;
            r_last_flags <= new_flags;
        end
    end

    assign old_flags = (r_last_valid && r_last_addr == r_s1_addr) ? r_last_flags
                                                                 : t_flags'(ram_rdata);

    ssdf_edit u_edit (
        .i_stage (r_s1),
        .i_cfg   (cfg),
        .i_flags (old_flags),
        .o_flags (new_flags)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_valid) begin
            r_out_row   <= r_s1.row;
            r_out_flags <= r_s1.in_range ? new_flags : '0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_row        = r_out_row;
    assign o_res.is_selected    = r_out_flags.sel;
    assign o_res.is_deleted     = r_out_flags.del;
    assign o_res.take_transform = r_out_flags.sel && !r_out_flags.del;
    // an out-of-range row reports all marks zero, keep included
    assign o_res.keep_row       = !r_out_flags.del && (r_out_flags.sel || r_out_keep);

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_valid) begin
            r_out_keep <= r_s1.in_range;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ssdf_ram.sv
// ----------------------------------------------------------------------------
// ssdf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ssdf_cfg.sv
// ----------------------------------------------------------------------------
// ssdf_cfg
// Box and opacity filter configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdf_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [ssdf_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [ssdf_pkg::CFG_DATA_W-1:0] i_data,
    output      ssdf_pkg::t_cfg                 o_cfg
);
    import ssdf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{center_x: '0, center_y: '0, center_z: '0,
                       half_x: '0, half_y: '0, half_z: '0,
                       mode: MODE_SET, thresh: THRESH_RESET};
        end else if (i_we) begin
            case (i_index)
                CFG_CENTER_X: r_cfg.center_x <= i_data[POS_W-1:0];
                CFG_CENTER_Y: r_cfg.center_y <= i_data[POS_W-1:0];
                CFG_CENTER_Z: r_cfg.center_z <= i_data[POS_W-1:0];
                CFG_HALF_X:   r_cfg.half_x   <= i_data[HALF_W-1:0];
                CFG_HALF_Y:   r_cfg.half_y   <= i_data[HALF_W-1:0];
                CFG_HALF_Z:   r_cfg.half_z   <= i_data[HALF_W-1:0];
                CFG_MODE:     r_cfg.mode     <= i_data[1:0];
                CFG_THRESH:   r_cfg.thresh   <= i_data[OPA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/ssdf_edit.sv
// ----------------------------------------------------------------------------
// ssdf_edit
// Applies one edit to a row's marks: box hit test and mark update.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdf_edit (
    input  wire ssdf_pkg::t_stage i_stage,
    input  wire ssdf_pkg::t_cfg   i_cfg,
    input  wire ssdf_pkg::t_flags i_flags,
    output      ssdf_pkg::t_flags o_flags
);
    import ssdf_pkg::*;

    function automatic logic axis_hit(
        input logic signed [DIFF_W-1:0] d,
        input logic [HALF_W-1:0]        half
    );
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = {2'b00, half};
        lo = DIFF_W'(0) - {2'b00, half};
        return (d <= hi) && (d >= lo);
    endfunction

    logic hit;

    assign hit = axis_hit(i_stage.dx, i_cfg.half_x)
               & axis_hit(i_stage.dy, i_cfg.half_y)
               & axis_hit(i_stage.dz, i_cfg.half_z);

    always_comb begin
        o_flags = i_flags;
        case (i_stage.req)
            REQ_CLEAR: begin
                o_flags = '0;
            end
            REQ_SEL_ALL: begin
                if (!i_flags.del) o_flags.sel = 1'b1;
            end
            REQ_SEL_NONE: begin
                o_flags.sel = 1'b0;
            end
            REQ_BOX: begin
                if (!i_flags.del) begin
                    case (i_cfg.mode)
                        MODE_SET:    o_flags.sel = hit;
                        MODE_ADD:    if (hit) o_flags.sel = 1'b1;
                        MODE_REMOVE: if (hit) o_flags.sel = 1'b0;
                        default: begin
                        end
                    endcase
                end
            end
            REQ_DELETE: begin
                if (i_flags.sel) o_flags = '{del: 1'b1, sel: 1'b0};
            end
            REQ_FILTER: begin
                if (i_stage.opa_lt) o_flags = '{del: 1'b1, sel: 1'b0};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: bench/tb_splat_select_delete_flags.sv
// ----------------------------------------------------------------------------
// tb_splat_select_delete_flags
// Self-checking bench for the splat select/delete flag block. A directed
// run walks the edits, box modes and threshold corners, then random phases
// hammer a small pool of rows under fresh box and threshold settings. A
// shadow flag store predicts each result beat, checked in order.
// ----------------------------------------------------------------------------
module tb_splat_select_delete_flags;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdf_pkg::*;

    localparam int         ROW_COUNT   = 65536;
    localparam int         RUN_LIMIT   = 2000000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 212;
    localparam int         PRINT_CAP   = 100;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] REQ_SPARE   = 3'd7;

    typedef struct packed {
        logic [2:0]              req;
        logic [ROW_W-1:0]        row;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [OPA_W-1:0] opa;
    } t_edit;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             sel;
        logic             del;
        logic             take;
        logic             keep;
    } t_marks;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ssdf_in_if  req_if ();
    ssdf_out_if res_if ();

    splat_select_delete_flags #(
        .ROW_COUNT(ROW_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    t_flags flag_store [ROW_COUNT];
    t_cfg   shadow_cfg;
    t_edit  edit_backlog [$];
    t_marks marks_due [$];
    t_edit  next_edit;
    t_edit  taken_edit;
    t_marks beat_want;
    logic   req_beat_taken;
    int     send_wait;
    int     res_wait;
    bit     send_idle;
    bit     recv_idle;
    int     fail_count;

    always #2 i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT);
        $display("FAIL splat_select_delete_flags");
        $finish;
    end

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, 8)) : 0;
    endfunction

    function automatic bit axis_hit(logic signed [POS_W-1:0] p, logic signed [POS_W-1:0] c,
                                    logic [HALF_W-1:0] h);
        logic signed [DIFF_W-1:0] d;
        d = p - c;
        if (d < 0) d = -d;
        return d <= $signed({2'b00, h});
    endfunction

    // read-modify-write of the shadow store, returns the row's marks after the edit
    function automatic t_marks apply_edit(t_edit e);
        t_flags f;
        t_marks m;
        bit     hit;
        m = '0;
        m.row = e.row;
        if (int'(e.row) >= ROW_COUNT) return m;
        f = flag_store[e.row];
        case (e.req)
            REQ_CLEAR:    f = '0;
            REQ_SEL_ALL:  if (!f.del) f.sel = 1'b1;
            REQ_SEL_NONE: f.sel = 1'b0;
            REQ_BOX: begin
                if (!f.del) begin
                    hit = axis_hit(e.pos_x, shadow_cfg.center_x, shadow_cfg.half_x) &&
                          axis_hit(e.pos_y, shadow_cfg.center_y, shadow_cfg.half_y) &&
                          axis_hit(e.pos_z, shadow_cfg.center_z, shadow_cfg.half_z);
                    case (shadow_cfg.mode)
                        MODE_SET:    f.sel = hit;
                        MODE_ADD:    if (hit) f.sel = 1'b1;
                        MODE_REMOVE: if (hit) f.sel = 1'b0;
                        default: ;
                    endcase
                end
            end
            REQ_DELETE: begin
                if (f.sel) begin
                    f.sel = 1'b0;
                    f.del = 1'b1;
                end
            end
            REQ_FILTER: begin
                if (e.opa < shadow_cfg.thresh) begin
                    f.sel = 1'b0;
                    f.del = 1'b1;
                end
            end
            default: ;
        endcase
        flag_store[e.row] = f;
        m.sel  = f.sel;
        m.del  = f.del;
        m.take = f.sel && !f.del;
        m.keep = !f.del;
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_CENTER_X: shadow_cfg.center_x = data;
            CFG_CENTER_Y: shadow_cfg.center_y = data;
            CFG_CENTER_Z: shadow_cfg.center_z = data;
            CFG_HALF_X:   shadow_cfg.half_x   = data[HALF_W-1:0];
            CFG_HALF_Y:   shadow_cfg.half_y   = data[HALF_W-1:0];
            CFG_HALF_Z:   shadow_cfg.half_z   = data[HALF_W-1:0];
            CFG_MODE:     shadow_cfg.mode     = data[1:0];
            CFG_THRESH:   shadow_cfg.thresh   = data[OPA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_box(int cx, int cy, int cz, int hx, int hy, int hz,
                               logic [1:0] mode, int thresh);
        write_reg(CFG_CENTER_X, 24'(cx));
        write_reg(CFG_CENTER_Y, 24'(cy));
        write_reg(CFG_CENTER_Z, 24'(cz));
        write_reg(CFG_HALF_X, 24'(hx));
        write_reg(CFG_HALF_Y, 24'(hy));
        write_reg(CFG_HALF_Z, 24'(hz));
        write_reg(CFG_MODE, {22'd0, mode});
        write_reg(CFG_THRESH, 24'(thresh));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_edit(logic [2:0] req, int row, int px, int py, int pz, int opa);
        t_edit e;
        e = '{req: req, row: 16'(row), pos_x: 24'(px), pos_y: 24'(py),
              pos_z: 24'(pz), opa: 16'(opa)};
        edit_backlog.insert(edit_backlog.size(), e);
    endtask

    // every queued beat sent and every result back, then the pipe has drained
    task automatic wait_idle();
        while (edit_backlog.size() != 0 || req_if.valid || marks_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // mostly inside or just outside the box so hits and misses both show up
    function automatic logic signed [POS_W-1:0] near_axis(logic signed [POS_W-1:0] c,
                                                          logic [HALF_W-1:0] h);
        int span;
        span = int'(h) + 2;
        if ($urandom_range(0, 9) < 6)
            return c + 24'(int'($urandom_range(0, 2 * span)) - span);
        return 24'($urandom);
    endfunction

    function automatic t_edit random_edit();
        t_edit e;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)       e.req = REQ_CLEAR;
        else if (pick < 20) e.req = REQ_SEL_ALL;
        else if (pick < 30) e.req = REQ_SEL_NONE;
        else if (pick < 60) e.req = REQ_BOX;
        else if (pick < 70) e.req = REQ_DELETE;
        else if (pick < 85) e.req = REQ_FILTER;
        else if (pick < 95) e.req = REQ_QUERY;
        else                e.req = REQ_SPARE;
        // a small pool of rows keeps edits landing on the same marks back to back
        pick = $urandom_range(0, 9);
        if (pick < 7)       e.row = 16'($urandom_range(0, 31));
        else if (pick == 7) e.row = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else                e.row = 16'($urandom);
        e.pos_x = near_axis(shadow_cfg.center_x, shadow_cfg.half_x);
        e.pos_y = near_axis(shadow_cfg.center_y, shadow_cfg.half_y);
        e.pos_z = near_axis(shadow_cfg.center_z, shadow_cfg.half_z);
        if ($urandom_range(0, 1))
            e.opa = shadow_cfg.thresh + 16'(int'($urandom_range(0, 8)) - 4);
        else
            e.opa = 16'($urandom);
        return e;
    endfunction

    function automatic int pick_center();
        case ($urandom_range(0, 4))
            0:       return -8388608;
            1:       return 8388607;
            2:       return int'($urandom_range(0, 8192)) - 4096;
            default: return int'(24'($urandom)) - (($urandom & 1) << 23);
        endcase
    endfunction

    function automatic int pick_half();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 8388607;
            2:       return $urandom_range(0, 8388607);
            default: return $urandom_range(0, 2048);
        endcase
    endfunction

    function automatic int pick_thresh();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_beat_taken) begin
            if (send_wait > 0) begin
                req_if.valid <= 1'b0;
                send_wait    <= send_wait - 1;
            end else if (edit_backlog.size() > 0) begin
                next_edit = edit_backlog.pop_front();
                req_if.req_type      <= next_edit.req;
                req_if.row_index     <= next_edit.row;
                req_if.pos_x         <= next_edit.pos_x;
                req_if.pos_y         <= next_edit.pos_y;
                req_if.pos_z         <= next_edit.pos_z;
                req_if.opacity_logit <= next_edit.opa;
                req_if.valid         <= 1'b1;
                send_wait            <= draw_wait(send_idle);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (res_wait > 0) begin
            res_if.ready <= 1'b0;
            res_wait     <= res_wait - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // monitor: predict on each request beat, check each result beat
    always @(posedge i_clk) begin
        if (req_if.valid && req_if.ready) begin
            taken_edit = '{req: req_if.req_type, row: req_if.row_index, pos_x: req_if.pos_x,
                           pos_y: req_if.pos_y, pos_z: req_if.pos_z,
                           opa: req_if.opacity_logit};
            marks_due.insert(marks_due.size(), apply_edit(taken_edit));
        end
        req_beat_taken <= req_if.valid && req_if.ready;
        if (res_if.valid && res_if.ready) begin
            if (marks_due.size() == 0) begin
                report_mismatch("result beat with nothing outstanding", res_if.out_row, 0);
            end else begin
                beat_want = marks_due.pop_front();
                if (res_if.out_row !== beat_want.row)
                    report_mismatch("out_row", res_if.out_row, beat_want.row);
                if (res_if.is_selected !== beat_want.sel)
                    report_mismatch("is_selected", res_if.is_selected, beat_want.sel);
                if (res_if.is_deleted !== beat_want.del)
                    report_mismatch("is_deleted", res_if.is_deleted, beat_want.del);
                if (res_if.take_transform !== beat_want.take)
                    report_mismatch("take_transform", res_if.take_transform, beat_want.take);
                if (res_if.keep_row !== beat_want.keep)
                    report_mismatch("keep_row", res_if.keep_row, beat_want.keep);
            end
            res_wait <= draw_wait(recv_idle);
        end
    end

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = '0;
        i_cfg_data           = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = '0;
        req_if.row_index     = '0;
        req_if.pos_x         = '0;
        req_if.pos_y         = '0;
        req_if.pos_z         = '0;
        req_if.opacity_logit = '0;
        res_if.ready         = 1'b0;
        req_beat_taken       = 1'b0;
        send_wait            = 0;
        res_wait             = 0;
        send_idle            = 1'b1;
        recv_idle            = 1'b1;
        fail_count           = 0;
        foreach (flag_store[i]) flag_store[i] = '0;
        shadow_cfg        = '0;
        shadow_cfg.mode   = MODE_SET;
        shadow_cfg.thresh = THRESH_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero-size box at the origin, threshold at the floor
        push_edit(REQ_QUERY, 0, 0, 0, 0, 0);
        push_edit(REQ_FILTER, 0, 0, 0, 0, -32768);
        push_edit(REQ_SEL_ALL, 0, 0, 0, 0, 0);
        push_edit(REQ_BOX, 0, 0, 0, 0, 0);
        push_edit(REQ_BOX, 0, 1, 0, 0, 0);
        push_edit(REQ_SEL_ALL, 65535, 0, 0, 0, 0);
        push_edit(REQ_DELETE, 65535, 0, 0, 0, 0);
        push_edit(REQ_SEL_ALL, 65535, 0, 0, 0, 0);
        push_edit(REQ_BOX, 65535, 0, 0, 0, 0);
        push_edit(REQ_DELETE, 0, 0, 0, 0, 0);
        push_edit(REQ_SPARE, 65535, 0, 0, 0, 0);
        push_edit(REQ_CLEAR, 65535, 0, 0, 0, 0);
        push_edit(REQ_SEL_ALL, 0, 0, 0, 0, 0);
        push_edit(REQ_SEL_NONE, 0, 0, 0, 0, 0);
        wait_idle();

        // box centred on the x and y range edges, full half size on x and z, threshold at the top
        program_box(-8388608, 8388607, 0, 8388607, 0, 8388607, MODE_ADD, 32767);
        push_edit(REQ_BOX, 1, -1, 8388607, 8388607, 0);
        push_edit(REQ_BOX, 2, 8388607, 8388607, 0, 0);
        push_edit(REQ_FILTER, 1, 0, 0, 0, 32767);
        push_edit(REQ_FILTER, 1, 0, 0, 0, 32766);
        wait_idle();

        program_box(-8388608, 8388607, 0, 8388607, 0, 8388607, MODE_REMOVE, 32767);
        push_edit(REQ_SEL_ALL, 3, 0, 0, 0, 0);
        push_edit(REQ_BOX, 3, -1, 8388607, 0, 0);
        wait_idle();

        program_box(-8388608, 8388607, 0, 8388607, 0, 8388607, MODE_UNUSED, 32767);
        push_edit(REQ_SEL_ALL, 4, 0, 0, 0, 0);
        push_edit(REQ_BOX, 4, -1, 8388607, 0, 0);
        push_edit(REQ_FILTER, 5, 0, 0, 0, -32768);
        wait_idle();

        // random phases, each under its own settings; the sender holds off at
        // every boundary until all results are back
        for (int p = 0; p < PHASES; p++) begin
            program_box(pick_center(), pick_center(), pick_center(),
                        pick_half(), pick_half(), pick_half(), 2'(p % 4), pick_thresh());
            send_idle = (p % 3 != 0) && (p != PHASES - 1);
            recv_idle = (p % 3 != 1) && (p != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                edit_backlog.insert(edit_backlog.size(), random_edit());
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("PASS splat_select_delete_flags");
        end else begin
            $display("FAIL splat_select_delete_flags");
        end
        $finish;
    end

endmodule
